FILE: rtl/fcsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsa_pkg
// shared types and constants of the contiguous slot allocator
// ----------------------------------------------------------------------------
package fcsa_pkg;

  // fixed field widths
  localparam int SLOT_COUNT_W  = 5;
  localparam int FIRST_SLOT_W  = 4;
  localparam int STATUS_W      = 3;
  localparam int TICKET_W      = 8;
  localparam int GRANT_START_W = 4;

  // grants handed out by one release at most
  localparam int MAX_GRANTS  = 8;
  localparam int GRANT_CNT_W = 4;

  // search sequencer: one step per bit of the count, one encode step, then done
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] SRCH_ENCODE = STEP_W'(SLOT_COUNT_W);
  localparam logic [STEP_W-1:0] SRCH_DONE   = STEP_W'(SLOT_COUNT_W + 1);

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED   = 3'd0,
    STAT_QUEUED    = 3'd1,
    STAT_BAD_SIZE  = 3'd2,
    STAT_Q_FULL    = 3'd3,
    STAT_BAD_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PEND_NEW_GRANT,
    PEND_Q_GRANT,
    PEND_QUEUED,
    PEND_BAD_SIZE,
    PEND_Q_FULL,
    PEND_BAD_RANGE
  } pend_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RES_SRCH,
    S_RES_DONE,
    S_REL_HEAD,
    S_REL_CHK,
    S_REL_SRCH,
    S_REL_DONE,
    S_SPILL,
    S_GRANT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       in_latch;
    logic       clr_range;
    logic       srch_start;
    logic       srch_from_q;
    logic       mark_range;
    logic       pend_load;
    pend_kind_t pend_kind;
    logic       enqueue;
    logic       pop;
    logic       tick_inc;
    logic       out_load;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic resv_bad;
    logic rel_bad;
    logic q_empty;
    logic q_full;
    logic srch_done;
    logic srch_found;
    logic grants_max;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/fcsa_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsa_search
// first-fit search for a run of free slots, one bit of the run length a cycle
// ----------------------------------------------------------------------------
module fcsa_search #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [fcsa_pkg::SLOT_COUNT_W-1:0]    count,
  input  wire logic [NUM_SLOTS-1:0]                 free,
  output logic                                      done,
  output logic                                      found,
  output logic [$clog2(NUM_SLOTS)-1:0]              first_idx
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  logic [fcsa_pkg::STEP_W-1:0]       step;
  logic [fcsa_pkg::SLOT_COUNT_W-1:0] count_r;
  // run_vec[i]: free run of the length built so far starts at i
  logic [NUM_SLOTS-1:0]              run_vec;
  // pow_vec[i]: free run of 2**step slots starts at i
  logic [NUM_SLOTS-1:0]              pow_vec;
  logic                              found_r;
  logic [IDX_W-1:0]                  idx_r;

  logic [fcsa_pkg::SLOT_COUNT_W-1:0] low_len;
  logic [fcsa_pkg::SLOT_COUNT_W-1:0] pow_shift;
  logic                              cur_bit;
  logic [IDX_W-1:0]                  idx_enc;

  always_comb begin
    pow_shift = fcsa_pkg::SLOT_COUNT_W'(1) << step;
    cur_bit   = |(count_r & pow_shift);
    for (int j = 0; j < fcsa_pkg::SLOT_COUNT_W; j++) begin
      low_len[j] = count_r[j] && (fcsa_pkg::STEP_W'(j) < step);
    end
  end

  // lowest starting run wins
  always_comb begin
    idx_enc = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (run_vec[i]) begin
        idx_enc = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fcsa_pkg::SRCH_DONE;
    end else if (start) begin
      step <= '0;
    end else if (step < fcsa_pkg::SRCH_ENCODE) begin
      step <= step + 1'b1;
    end else if (step == fcsa_pkg::SRCH_ENCODE) begin
      step <= fcsa_pkg::SRCH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count_r <= count;
      run_vec <= '1;
      pow_vec <= free;
    end else if (step < fcsa_pkg::SRCH_ENCODE) begin
      if (cur_bit) begin
        run_vec <= run_vec & (pow_vec >> low_len);
      end
      pow_vec <= pow_vec & (pow_vec >> pow_shift);
    end else if (step == fcsa_pkg::SRCH_ENCODE) begin
      found_r <= |run_vec;
      idx_r   <= idx_enc;
    end
  end

  assign done      = (step == fcsa_pkg::SRCH_DONE);
  assign found     = found_r;
  assign first_idx = idx_r;

endmodule
`default_nettype wire

FILE: rtl/fcsa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsa_datapath
// occupancy map, wait queue, search unit, ticket counter, result staging and output register
// ----------------------------------------------------------------------------
module fcsa_datapath #(
  parameter int NUM_SLOTS   = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_cmd,
  input  wire logic [fcsa_pkg::SLOT_COUNT_W-1:0]     in_count,
  input  wire logic [fcsa_pkg::FIRST_SLOT_W-1:0]     in_first,
  input  wire fcsa_pkg::ctrl_cmd_t                   cmd,
  output fcsa_pkg::dp_status_t                       status,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [fcsa_pkg::STATUS_W-1:0]              out_status,
  output logic [fcsa_pkg::TICKET_W-1:0]              out_ticket,
  output logic [fcsa_pkg::GRANT_START_W-1:0]         out_start,
  output logic                                       out_last
);

  localparam int IDX_W   = $clog2(NUM_SLOTS);
  localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TSUM_W  = FILL_W + 1;
  localparam int ENTRY_W = fcsa_pkg::SLOT_COUNT_W + fcsa_pkg::TICKET_W;

  // latched input item
  logic                              cmd_r;
  logic [fcsa_pkg::SLOT_COUNT_W-1:0] k_r;
  logic [fcsa_pkg::FIRST_SLOT_W-1:0] first_r;

  logic [NUM_SLOTS-1:0]              occ_map;
  logic [ENTRY_W-1:0]                q_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]                q_rd;
  logic [QIDX_W-1:0]                 head;
  logic [QIDX_W-1:0]                 tail;
  logic [FILL_W-1:0]                 fill;
  logic [fcsa_pkg::TICKET_W-1:0]     ticket;
  logic [fcsa_pkg::GRANT_CNT_W-1:0]  grant_n;
  logic [fcsa_pkg::SLOT_COUNT_W-1:0] srch_cnt;

  logic                               pend_valid;
  fcsa_pkg::status_t                  pend_status;
  logic [fcsa_pkg::TICKET_W-1:0]      pend_ticket;
  logic [fcsa_pkg::GRANT_START_W-1:0] pend_start;

  fcsa_pkg::status_t                  pend_status_next;
  logic [fcsa_pkg::TICKET_W-1:0]      pend_ticket_next;
  logic [fcsa_pkg::GRANT_START_W-1:0] pend_start_next;

  logic [fcsa_pkg::SLOT_COUNT_W-1:0]  q_rd_cnt;
  logic [fcsa_pkg::TICKET_W-1:0]      q_rd_tick;
  logic [fcsa_pkg::SLOT_COUNT_W-1:0]  srch_cnt_in;
  logic                               srch_done;
  logic                               srch_found;
  logic [IDX_W-1:0]                   srch_idx;
  logic [IDX_W+fcsa_pkg::GRANT_START_W-1:0] idx_ext;
  logic [TSUM_W-1:0]                  tail_sum;
  logic [NUM_SLOTS-1:0]               rng_mask;
  logic                               out_free;

  assign q_rd_cnt    = q_rd[ENTRY_W-1:fcsa_pkg::TICKET_W];
  assign q_rd_tick   = q_rd[fcsa_pkg::TICKET_W-1:0];
  assign srch_cnt_in = cmd.srch_from_q ? q_rd_cnt : k_r;
  assign idx_ext     = {{fcsa_pkg::GRANT_START_W{1'b0}}, srch_idx};
  assign out_free    = !out_valid || out_ready;

  fcsa_search #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.srch_start),
    .count     (srch_cnt_in),
    .free      (~occ_map),
    .done      (srch_done),
    .found     (srch_found),
    .first_idx (srch_idx)
  );

  // queue write slot: (head + fill) wrapped at the depth
  always_comb begin
    tail_sum = TSUM_W'(head) + TSUM_W'(fill);
    if (tail_sum >= TSUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - TSUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[QIDX_W-1:0];
  end

  // slot range to mark busy (found run) or to free (release)
  always_comb begin
    int lo;
    int hi;
    if (cmd.mark_range) begin
      lo = int'(srch_idx);
      hi = lo + int'(srch_cnt);
    end else begin
      lo = int'(first_r);
      hi = lo + int'(k_r);
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rng_mask[i] = (i >= lo) && (i < hi);
    end
  end

  always_comb begin
    pend_status_next = fcsa_pkg::STAT_BAD_SIZE;
    pend_ticket_next = '0;
    pend_start_next  = '0;
    unique case (cmd.pend_kind)
      fcsa_pkg::PEND_NEW_GRANT: begin
        pend_status_next = fcsa_pkg::STAT_GRANTED;
        pend_ticket_next = ticket;
        pend_start_next  = idx_ext[fcsa_pkg::GRANT_START_W-1:0];
      end
      fcsa_pkg::PEND_Q_GRANT: begin
        pend_status_next = fcsa_pkg::STAT_GRANTED;
        pend_ticket_next = q_rd_tick;
        pend_start_next  = idx_ext[fcsa_pkg::GRANT_START_W-1:0];
      end
      fcsa_pkg::PEND_QUEUED: begin
        pend_status_next = fcsa_pkg::STAT_QUEUED;
        pend_ticket_next = ticket;
      end
      fcsa_pkg::PEND_BAD_SIZE:  pend_status_next = fcsa_pkg::STAT_BAD_SIZE;
      fcsa_pkg::PEND_Q_FULL:    pend_status_next = fcsa_pkg::STAT_Q_FULL;
      fcsa_pkg::PEND_BAD_RANGE: pend_status_next = fcsa_pkg::STAT_BAD_RANGE;
      default:                  pend_status_next = fcsa_pkg::STAT_BAD_SIZE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_map    <= '0;
      head       <= '0;
      fill       <= '0;
      ticket     <= '0;
      grant_n    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.mark_range) begin
        occ_map <= occ_map | rng_mask;
      end else if (cmd.clr_range) begin
        occ_map <= occ_map & ~rng_mask;
      end
      if (cmd.enqueue) begin
        fill <= fill + 1'b1;
      end else if (cmd.pop) begin
        fill <= fill - 1'b1;
        head <= (head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (cmd.tick_inc) begin
        ticket <= ticket + 1'b1;
      end
      if (cmd.in_latch) begin
        grant_n <= '0;
      end else if (cmd.pop) begin
        grant_n <= grant_n + 1'b1;
      end
      if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end else if (cmd.in_latch || cmd.out_load) begin
        pend_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_latch) begin
      cmd_r   <= in_cmd;
      k_r     <= in_count;
      first_r <= in_first;
    end
    if (cmd.srch_start) begin
      srch_cnt <= srch_cnt_in;
    end
    if (cmd.pend_load) begin
      pend_status <= pend_status_next;
      pend_ticket <= pend_ticket_next;
      pend_start  <= pend_start_next;
    end
    if (cmd.out_load) begin
      out_status <= pend_status;
      out_ticket <= pend_ticket;
      out_start  <= pend_start;
      out_last   <= cmd.out_last;
    end
  end

  // wait queue memory, registered read of the head entry
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      q_mem[tail] <= {k_r, ticket};
    end
    q_rd <= q_mem[head];
  end

  always_comb begin
    status.is_release = cmd_r;
    status.resv_bad   = (k_r == '0) || (int'(k_r) > NUM_SLOTS);
    status.rel_bad    = (k_r == '0) || ((int'(first_r) + int'(k_r)) > NUM_SLOTS);
    status.q_empty    = (fill == '0);
    status.q_full     = (fill == FILL_W'(QUEUE_DEPTH));
    status.srch_done  = srch_done;
    status.srch_found = srch_found;
    status.grants_max = (grant_n == fcsa_pkg::GRANT_CNT_W'(fcsa_pkg::MAX_GRANTS));
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

endmodule
`default_nettype wire

FILE: rtl/fcsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsa_ctrl
// sequencer for reserve and release handling
// ----------------------------------------------------------------------------
module fcsa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fcsa_pkg::dp_status_t status,
  output fcsa_pkg::ctrl_cmd_t       cmd
);

  fcsa_pkg::state_t state;
  fcsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fcsa_pkg::S_IDLE: begin
        if (in_valid) state_next = fcsa_pkg::S_CHECK;
      end
      fcsa_pkg::S_CHECK: begin
        if (status.is_release) begin
          state_next = status.rel_bad ? fcsa_pkg::S_OUT : fcsa_pkg::S_REL_HEAD;
        end else if (!status.resv_bad && status.q_empty) begin
          state_next = fcsa_pkg::S_RES_SRCH;
        end else begin
          state_next = fcsa_pkg::S_OUT;
        end
      end
      fcsa_pkg::S_RES_SRCH: begin
        if (status.srch_done) state_next = fcsa_pkg::S_RES_DONE;
      end
      fcsa_pkg::S_RES_DONE: state_next = fcsa_pkg::S_OUT;
      fcsa_pkg::S_REL_HEAD: state_next = fcsa_pkg::S_REL_CHK;
      fcsa_pkg::S_REL_CHK: begin
        if (status.q_empty || status.grants_max) begin
          state_next = status.pend_valid ? fcsa_pkg::S_OUT : fcsa_pkg::S_IDLE;
        end else begin
          state_next = fcsa_pkg::S_REL_SRCH;
        end
      end
      fcsa_pkg::S_REL_SRCH: begin
        if (status.srch_done) state_next = fcsa_pkg::S_REL_DONE;
      end
      fcsa_pkg::S_REL_DONE: begin
        if (status.srch_found) begin
          state_next = status.pend_valid ? fcsa_pkg::S_SPILL : fcsa_pkg::S_GRANT;
        end else begin
          state_next = status.pend_valid ? fcsa_pkg::S_OUT : fcsa_pkg::S_IDLE;
        end
      end
      fcsa_pkg::S_SPILL: begin
        if (status.out_free) state_next = fcsa_pkg::S_GRANT;
      end
      fcsa_pkg::S_GRANT: state_next = fcsa_pkg::S_REL_HEAD;
      fcsa_pkg::S_OUT: begin
        if (status.out_free) state_next = fcsa_pkg::S_IDLE;
      end
      default: state_next = fcsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.pend_kind = fcsa_pkg::PEND_NEW_GRANT;
    in_ready      = 1'b0;
    unique case (state)
      fcsa_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.in_latch = in_valid;
      end
      fcsa_pkg::S_CHECK: begin
        if (status.is_release) begin
          if (status.rel_bad) begin
            cmd.pend_load = 1'b1;
            cmd.pend_kind = fcsa_pkg::PEND_BAD_RANGE;
          end else begin
            cmd.clr_range = 1'b1;
          end
        end else if (status.resv_bad) begin
          cmd.pend_load = 1'b1;
          cmd.pend_kind = fcsa_pkg::PEND_BAD_SIZE;
        end else if (status.q_empty) begin
          cmd.srch_start = 1'b1;
        end else if (status.q_full) begin
          cmd.pend_load = 1'b1;
          cmd.pend_kind = fcsa_pkg::PEND_Q_FULL;
        end else begin
          cmd.enqueue   = 1'b1;
          cmd.tick_inc  = 1'b1;
          cmd.pend_load = 1'b1;
          cmd.pend_kind = fcsa_pkg::PEND_QUEUED;
        end
      end
      fcsa_pkg::S_RES_DONE: begin
        cmd.pend_load = 1'b1;
        cmd.tick_inc  = 1'b1;
        if (status.srch_found) begin
          cmd.mark_range = 1'b1;
          cmd.pend_kind  = fcsa_pkg::PEND_NEW_GRANT;
        end else begin
          // queue was empty, so there is always room
          cmd.enqueue   = 1'b1;
          cmd.pend_kind = fcsa_pkg::PEND_QUEUED;
        end
      end
      fcsa_pkg::S_REL_CHK: begin
        if (!(status.q_empty || status.grants_max)) begin
          cmd.srch_start  = 1'b1;
          cmd.srch_from_q = 1'b1;
        end
      end
      fcsa_pkg::S_SPILL: begin
        cmd.out_load = status.out_free;
        cmd.out_last = 1'b0;
      end
      fcsa_pkg::S_GRANT: begin
        cmd.mark_range = 1'b1;
        cmd.pend_load  = 1'b1;
        cmd.pend_kind  = fcsa_pkg::PEND_Q_GRANT;
        cmd.pop        = 1'b1;
      end
      fcsa_pkg::S_OUT: begin
        cmd.out_load = status.out_free;
        cmd.out_last = 1'b1;
      end
      default: begin
        cmd.out_load = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/fifo_contiguous_slot_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_contiguous_slot_allocator_top
// first-fit contiguous slot allocator with a ticket-ordered wait queue
// ----------------------------------------------------------------------------
// One input transaction at a time is handled: a reserve (tuser 0) asks for
// slot_count contiguous slots, a release (tuser 1) frees slot_count slots from
// first_slot on and then grants waiting requests from the queue head, in
// ticket order, for as long as the head fits (at most eight per release). A
// reserve, a rejected item or a queued request gives exactly one result; a
// release gives one result per grant, or none when nothing can be granted.
// tlast marks the final result of an input. The input is ready only while no
// item is in progress; the last result sits in an output register while the
// next item is taken in. A reject, or a reserve that joins a non-empty queue,
// loads its result in the check state and presents it from the output state,
// after which the sequencer returns to idle. A reserve that finds the queue
// empty runs the first-fit search and loads its result, a grant or a queued
// status, when the search is done. A release frees the range in the check
// state and reads the queue head; with nothing waiting it then goes back to
// idle with no result. Each grant runs a search for the head entry, and from
// the second grant on the previous grant is first passed to the output
// register; a final head that does not fit runs one more search. A grant
// result leaves once the next head has been checked, the last one after the
// final check. The search builds the run length one bit of slot_count per
// cycle after its start cycle, then picks the lowest start in an encode step
// and then reports done. A stalled receiver adds its stall to every result
// that has to leave before the sequencer can go on.
// ----------------------------------------------------------------------------
module fifo_contiguous_slot_allocator_top #(
  parameter int NUM_SLOTS   = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transactions
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [4:0] slot_count, [8:5] first_slot, rest zero
  input  wire logic [0:0]  s_tuser,   // [0] cmd: 0 reserve, 1 release
  // result transactions
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] ticket, [11:8] grant_start, rest zero
  output logic [2:0]       m_tuser,   // [2:0] status
  output logic             m_tlast
);

  fcsa_pkg::ctrl_cmd_t  cmd;
  fcsa_pkg::dp_status_t status;

  logic [fcsa_pkg::TICKET_W-1:0]      res_ticket;
  logic [fcsa_pkg::GRANT_START_W-1:0] res_start;

  // sequencer: decides each step from the datapath flags
  fcsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // map, queue, search unit and result registers
  fcsa_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_tuser[0]),
    .in_count   (s_tdata[4:0]),
    .in_first   (s_tdata[8:5]),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_ticket (res_ticket),
    .out_start  (res_start),
    .out_last   (m_tlast)
  );

  // pack the result payload, pad to whole bytes
  assign m_tdata = {4'b0000, res_start, res_ticket};

endmodule
`default_nettype wire
